@@ sv/twc_pkg.sv @@
// Shared types, codes and constants of the traverse winder controller.
`default_nettype none

package twc_pkg;

	localparam int DEF_POSITION_BITS   = 32;
	localparam int DEF_HOME_WAIT_TICKS = 100;

	localparam int CMD_W       = 4;
	localparam int STEP_W      = 20;
	localparam int TRAVEL_W    = 29;
	localparam int MAG_W       = 21;
	localparam int WAIT_W      = 7;
	localparam int FIELD_POS_W = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 29;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 112;

	localparam logic [STEP_W-1:0]   STEP_SIZE_RST  = STEP_W'(640);
	localparam logic [TRAVEL_W-1:0] MAX_TRAVEL_RST = TRAVEL_W'(640000);
	// Revolution step for the reset step size: (27 * 640 + 10) / 20.
	localparam logic [MAG_W-1:0]    MAG_RST        = MAG_W'(864);
	// Ceiling of 2^26 / 5; exact quotient for dividends below 2^26.
	localparam logic [23:0]         DIV5_RECIP     = 24'd13421773;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 4'd0,
		CMD_REV       = 4'd1,
		CMD_LEFT      = 4'd2,
		CMD_RIGHT     = 4'd3,
		CMD_REHOME    = 4'd4,
		CMD_CALIBRATE = 4'd5,
		CMD_START_INC = 4'd6,
		CMD_START_DEC = 4'd7,
		CMD_END_INC   = 4'd8,
		CMD_END_DEC   = 4'd9
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STEP_SIZE  = 1'b0,
		REG_MAX_TRAVEL = 1'b1
	} reg_index_t;

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_HOMING  = 6'b000010,
		MODE_TO_HOME = 6'b000100,
		MODE_CALIB   = 6'b001000,
		MODE_WAIT    = 6'b010000,
		MODE_AUTO    = 6'b100000
	} mode_t;

	typedef enum logic [1:0] {
		SS_KEEP    = 2'd0,
		SS_ENABLE  = 2'd1,
		SS_DISABLE = 2'd2
	} stall_stop_t;

	localparam logic [2:0] CODE_IDLE    = 3'd0;
	localparam logic [2:0] CODE_HOMING  = 3'd1;
	localparam logic [2:0] CODE_TO_HOME = 3'd2;
	localparam logic [2:0] CODE_CALIB   = 3'd3;
	localparam logic [2:0] CODE_WAIT    = 3'd4;
	localparam logic [2:0] CODE_AUTO    = 3'd5;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		c = CODE_IDLE;
		unique case (m)
			MODE_IDLE:    c = CODE_IDLE;
			MODE_HOMING:  c = CODE_HOMING;
			MODE_TO_HOME: c = CODE_TO_HOME;
			MODE_CALIB:   c = CODE_CALIB;
			MODE_WAIT:    c = CODE_WAIT;
			MODE_AUTO:    c = CODE_AUTO;
			default:      c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/traverse_winder_controller.sv @@
// Traverse winder controller: command decode, homing and calibration sequencing.
//
// Input words arrive on the s_axis channel: tuser carries the command and tdata
// the driver flags and the actual motor position. Every input word yields exactly
// one output word on the m_axis channel with the target write, zeroing request,
// stall-stop setting, parameter set, reinit request, mode and effective limits.
// Registers step_size and max_travel are written through the cfg channel, which
// is always ready; write them only while no word is in flight.
// A word is taken into an input register, evaluated combinationally against the
// controller state, and lands in the output register, which drives m_axis_tvalid.
// While the receiver keeps m_axis_tready high, one word per cycle is sustained.
// The single state update per cycle is what sets that rate.
// When the receiver stalls, the output register holds its word and the input
// register fills; s_axis_tready drops only once both are occupied.
// The asynchronous reset empties both registers, puts the controller in idle
// with uncalibrated limits spanning zero to max_travel, and loads the register
// defaults of 640 and 640000.
`default_nettype none

module traverse_winder_controller
	import twc_pkg::*;
#(
	parameter int POSITION_BITS   = DEF_POSITION_BITS,
	parameter int HOME_WAIT_TICKS = DEF_HOME_WAIT_TICKS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// stalled, position_reached, actual_position, driver_enabled, after_error.
	input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
	// command.
	input  wire logic [CMD_W-1:0]       s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// target_write, target_position, zero_positions, stall_stop, calibration_mode,
	// driver_reinit, state_code, calibrated, limit_start, limit_end.
	output logic [OUT_DATA_W-1:0]       m_axis_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int PB = POSITION_BITS;
	localparam int SB = ((PB > MAG_W) ? PB : MAG_W) + 2;
	localparam logic signed [PB-1:0] SpoolEndRst = PB'(MAX_TRAVEL_RST);
	localparam logic signed [PB-1:0] EffLoRst = SpoolEndRst[PB-1] ? SpoolEndRst : '0;
	localparam logic signed [PB-1:0] EffHiRst = SpoolEndRst[PB-1] ? '0 : SpoolEndRst;

	// Configuration registers and the derived revolution step.
	logic [STEP_W-1:0]   step_size_q;
	logic [TRAVEL_W-1:0] max_travel_q;
	logic [MAG_W-1:0]    mag_q;
	logic [24:0]         cfg_scaled;
	logic [22:0]         cfg_quarter;
	logic [46:0]         cfg_prod;

	// Input register.
	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic                 stalled_s1;
	logic                 reached_s1;
	logic signed [PB-1:0] actual_s1;
	logic                 drv_en_s1;
	logic                 aft_err_s1;

	// Output register.
	logic                   valid_s2;
	logic                   wr_s2;
	logic [FIELD_POS_W-1:0] target_s2;
	logic                   zero_s2;
	stall_stop_t            ss_s2;
	logic                   lowc_s2;
	logic                   reinit_s2;
	logic [2:0]             code_s2;
	logic                   cal_s2;
	logic [FIELD_POS_W-1:0] lo_s2;
	logic [FIELD_POS_W-1:0] hi_s2;

	// Controller state.
	mode_t                mode_q;
	mode_t                resume_q;
	logic [WAIT_W-1:0]    wait_q;
	logic signed [PB-1:0] target_q;
	logic                 back_q;
	logic signed [PB-1:0] sstart_q;
	logic signed [PB-1:0] send_q;
	logic signed [PB-1:0] sext_q;
	logic signed [PB-1:0] eext_q;
	logic                 scap_q;
	logic                 ecap_q;
	logic                 errh_q;
	logic                 lowc_q;
	logic signed [PB-1:0] eff_lo_q;
	logic signed [PB-1:0] eff_hi_q;

	mode_t                mode_n;
	mode_t                resume_n;
	logic [WAIT_W-1:0]    wait_n;
	logic signed [PB-1:0] target_n;
	logic                 back_n;
	logic signed [PB-1:0] sstart_n;
	logic signed [PB-1:0] send_n;
	logic signed [PB-1:0] sext_n;
	logic signed [PB-1:0] eext_n;
	logic                 scap_n;
	logic                 ecap_n;
	logic                 errh_n;
	logic                 lowc_n;
	logic signed [PB-1:0] s_n;
	logic signed [PB-1:0] e_n;
	logic signed [PB-1:0] eff_lo_n;
	logic signed [PB-1:0] eff_hi_n;

	logic        wr;
	logic        zero;
	stall_stop_t ss;
	logic        reinit;
	logic        adv;

	logic [31:0]          max32;
	logic [31:0]          two_max32;
	logic [31:0]          neg_max32;
	logic [31:0]          neg_two_max32;
	logic [31:0]          half_max32;
	logic [PB-1:0]        step_pos;
	logic [WAIT_W-1:0]    wait_inc;
	logic signed [SB-1:0] tgt_x;
	logic signed [SB-1:0] lo_x;
	logic signed [SB-1:0] hi_x;
	logic signed [SB-1:0] step_x;
	logic signed [SB-1:0] mag_x;
	logic signed [SB-1:0] left_sum;
	logic signed [SB-1:0] right_sum;
	logic signed [SB-1:0] rev_sum;
	logic signed [PB-1:0] left_pos;
	logic signed [PB-1:0] right_pos;
	logic signed [PB-1:0] rev_pos;
	logic                 rev_back;

	// Configuration port; the revolution step 27/20 of step_size is formed at write time.
	assign cfg_ready   = 1'b1;
	assign cfg_scaled  = 25'(cfg_data[STEP_W-1:0]) * 25'd27 + 25'd10;
	assign cfg_quarter = cfg_scaled[24:2];
	assign cfg_prod    = 47'(cfg_quarter) * 47'(DIV5_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q  <= STEP_SIZE_RST;
			max_travel_q <= MAX_TRAVEL_RST;
			mag_q        <= MAG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_STEP_SIZE: begin
					step_size_q <= cfg_data[STEP_W-1:0];
					mag_q       <= cfg_prod[26+MAG_W-1:26];
				end
				REG_MAX_TRAVEL: begin
					max_travel_q <= cfg_data[TRAVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake between the two registers.
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1     <= cmd_t'(s_axis_tuser);
			stalled_s1 <= s_axis_tdata[0];
			reached_s1 <= s_axis_tdata[1];
			actual_s1  <= s_axis_tdata[PB+1:2];
			drv_en_s1  <= s_axis_tdata[34];
			aft_err_s1 <= s_axis_tdata[35];
		end
	end

	// Derived positions, all wrapped to the position width.
	assign max32         = 32'(max_travel_q);
	assign two_max32     = {2'b00, max_travel_q, 1'b0};
	assign neg_max32     = 32'd0 - max32;
	assign neg_two_max32 = 32'd0 - two_max32;
	assign half_max32    = 32'(max_travel_q[TRAVEL_W-1:1]);
	assign step_pos      = PB'(step_size_q);
	assign wait_inc      = (wait_q == {WAIT_W{1'b1}}) ? wait_q : wait_q + 1'b1;

	// Clamped moves are summed exactly in a wider word.
	assign tgt_x     = SB'(target_q);
	assign lo_x      = SB'(eff_lo_q);
	assign hi_x      = SB'(eff_hi_q);
	assign step_x    = $signed(SB'(step_size_q));
	assign mag_x     = $signed(SB'(mag_q));
	assign left_sum  = tgt_x - step_x;
	assign right_sum = tgt_x + step_x;
	assign rev_sum   = back_q ? (tgt_x - mag_x) : (tgt_x + mag_x);

	always_comb begin
		left_pos = PB'(left_sum);
		if (left_sum > hi_x) begin
			left_pos = eff_hi_q;
		end else if (left_sum < lo_x) begin
			left_pos = eff_lo_q;
		end
		right_pos = PB'(right_sum);
		if (right_sum > hi_x) begin
			right_pos = eff_hi_q;
		end else if (right_sum < lo_x) begin
			right_pos = eff_lo_q;
		end
		rev_pos  = PB'(rev_sum);
		rev_back = back_q;
		if (rev_sum >= hi_x) begin
			rev_pos  = eff_hi_q;
			rev_back = 1'b1;
		end else if (rev_sum <= lo_x) begin
			rev_pos  = eff_lo_q;
			rev_back = 1'b0;
		end
	end

	// Command evaluation.
	always_comb begin
		mode_n   = mode_q;
		resume_n = resume_q;
		wait_n   = wait_q;
		target_n = target_q;
		back_n   = back_q;
		sstart_n = sstart_q;
		send_n   = send_q;
		sext_n   = sext_q;
		eext_n   = eext_q;
		scap_n   = scap_q;
		ecap_n   = ecap_q;
		errh_n   = errh_q;
		lowc_n   = lowc_q;
		wr       = 1'b0;
		zero     = 1'b0;
		ss       = SS_KEEP;
		reinit   = 1'b0;
		case (cmd_s1) inside
			CMD_TICK: begin
				unique case (mode_q)
					MODE_HOMING: begin
						if (stalled_s1) begin
							ss       = SS_DISABLE;
							zero     = 1'b1;
							target_n = '0;
							wait_n   = '0;
							resume_n = MODE_TO_HOME;
							mode_n   = MODE_WAIT;
						end else begin
							target_n = two_max32[PB-1:0];
							wr       = 1'b1;
						end
					end
					MODE_TO_HOME: begin
						target_n = neg_max32[PB-1:0];
						wr       = 1'b1;
						if (reached_s1) begin
							zero = 1'b1;
							if (!errh_q) begin
								target_n = half_max32[PB-1:0];
								mode_n   = MODE_IDLE;
							end else begin
								target_n = eff_lo_q;
								mode_n   = MODE_AUTO;
							end
						end
					end
					MODE_CALIB: begin
						if (stalled_s1) begin
							ss = SS_DISABLE;
							if (!scap_q) begin
								sstart_n = actual_s1;
								scap_n   = 1'b1;
								target_n = two_max32[PB-1:0];
								wr       = 1'b1;
								ss       = SS_ENABLE;
							end else if (!ecap_q) begin
								send_n   = actual_s1;
								ecap_n   = 1'b1;
								lowc_n   = 1'b0;
								target_n = sstart_q;
								wr       = 1'b1;
							end
						end else if (scap_q && ecap_q && reached_s1) begin
							mode_n = MODE_AUTO;
						end
					end
					MODE_WAIT: begin
						wait_n = wait_inc;
						if (wait_inc >= WAIT_W'(HOME_WAIT_TICKS)) begin
							mode_n = resume_q;
						end
					end
					default: begin
					end
				endcase
				if (!drv_en_s1) begin
					reinit   = 1'b1;
					errh_n   = 1'b1;
					zero     = 1'b1;
					target_n = max32[PB-1:0];
					wr       = 1'b1;
					ss       = SS_ENABLE;
					mode_n   = MODE_HOMING;
				end
			end
			CMD_REV: begin
				if (mode_q == MODE_AUTO) begin
					target_n = rev_pos;
					back_n   = rev_back;
					wr       = 1'b1;
				end
			end
			CMD_LEFT: begin
				target_n = left_pos;
				wr       = 1'b1;
			end
			CMD_RIGHT: begin
				target_n = right_pos;
				wr       = 1'b1;
			end
			CMD_REHOME: begin
				errh_n = aft_err_s1;
				if (!aft_err_s1) begin
					scap_n   = 1'b0;
					ecap_n   = 1'b0;
					sstart_n = '0;
					send_n   = max32[PB-1:0];
					sext_n   = '0;
					eext_n   = '0;
				end
				zero     = 1'b1;
				target_n = max32[PB-1:0];
				wr       = 1'b1;
				ss       = SS_ENABLE;
				mode_n   = MODE_HOMING;
			end
			CMD_CALIBRATE: begin
				lowc_n   = 1'b1;
				ss       = SS_ENABLE;
				target_n = neg_two_max32[PB-1:0];
				wr       = 1'b1;
				mode_n   = MODE_CALIB;
			end
			CMD_START_INC, CMD_START_DEC, CMD_END_INC, CMD_END_DEC: begin
				if (scap_q && ecap_q) begin
					case (cmd_s1)
						CMD_START_INC: sext_n = sext_q + step_pos;
						CMD_START_DEC: sext_n = sext_q - step_pos;
						CMD_END_INC:   eext_n = eext_q + step_pos;
						default:       eext_n = eext_q - step_pos;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Effective limits after this word.
	assign s_n      = sstart_n - sext_n;
	assign e_n      = send_n + eext_n;
	assign eff_lo_n = (s_n <= e_n) ? s_n : e_n;
	assign eff_hi_n = (s_n <= e_n) ? e_n : s_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			resume_q <= MODE_IDLE;
			wait_q   <= '0;
			target_q <= '0;
			back_q   <= 1'b0;
			sstart_q <= '0;
			send_q   <= SpoolEndRst;
			sext_q   <= '0;
			eext_q   <= '0;
			scap_q   <= 1'b0;
			ecap_q   <= 1'b0;
			errh_q   <= 1'b0;
			lowc_q   <= 1'b0;
			eff_lo_q <= EffLoRst;
			eff_hi_q <= EffHiRst;
		end else if (adv) begin
			mode_q   <= mode_n;
			resume_q <= resume_n;
			wait_q   <= wait_n;
			target_q <= target_n;
			back_q   <= back_n;
			sstart_q <= sstart_n;
			send_q   <= send_n;
			sext_q   <= sext_n;
			eext_q   <= eext_n;
			scap_q   <= scap_n;
			ecap_q   <= ecap_n;
			errh_q   <= errh_n;
			lowc_q   <= lowc_n;
			eff_lo_q <= eff_lo_n;
			eff_hi_q <= eff_hi_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s2     <= wr;
			target_s2 <= FIELD_POS_W'(target_n);
			zero_s2   <= zero;
			ss_s2     <= ss;
			lowc_s2   <= lowc_n;
			reinit_s2 <= reinit;
			code_s2   <= mode_code(mode_n);
			cal_s2    <= scap_n && ecap_n;
			lo_s2     <= FIELD_POS_W'(eff_lo_n);
			hi_s2     <= FIELD_POS_W'(eff_hi_n);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b000000, hi_s2, lo_s2, cal_s2, code_s2, reinit_s2, lowc_s2,
		ss_s2, zero_s2, target_s2, wr_s2};

endmodule

`default_nettype wire

@@ test/tb_traverse_winder_controller.sv @@
// Self-checking testbench for the traverse winder controller with a built-in predictor.
`timescale 1ns / 100ps

module tb_traverse_winder_controller;
	import twc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

	localparam int O_WR     = 0;
	localparam int O_TARGET = 1;
	localparam int O_ZERO   = 33;
	localparam int O_SS     = 34;
	localparam int O_CMODE  = 36;
	localparam int O_REINIT = 37;
	localparam int O_CODE   = 38;
	localparam int O_CAL    = 41;
	localparam int O_LO     = 42;
	localparam int O_HI     = 74;

	typedef struct {
		logic [CMD_W-1:0]              cmd;
		logic                          stalled;
		logic                          reached;
		logic signed [FIELD_POS_W-1:0] actual;
		logic                          drv_en;
		logic                          aft_err;
	} command_t;

	typedef struct {
		logic                          wr_target;
		logic signed [FIELD_POS_W-1:0] target;
		logic                          zero_pos;
		stall_stop_t                   stall_stop;
		logic                          cal_mode;
		logic                          reinit;
		logic [2:0]                    code;
		logic                          calibrated;
		logic signed [FIELD_POS_W-1:0] lim_lo;
		logic signed [FIELD_POS_W-1:0] lim_hi;
	} result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [CMD_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	command_t queued_commands[$];
	result_t  due_results[$];
	command_t cur_cmd;
	int       queued = 0;
	int       checked = 0;
	int       errors = 0;
	int       send_pause = 0;
	int       recv_pause = 0;
	bit       quiet = 1'b0;

	logic [STEP_W-1:0]             cfg_step = STEP_SIZE_RST;
	logic [TRAVEL_W-1:0]           cfg_travel = MAX_TRAVEL_RST;
	logic [2:0]                    wmode = CODE_IDLE;
	logic [2:0]                    back_mode = CODE_IDLE;
	logic [WAIT_W-1:0]             tick_count = '0;
	logic signed [FIELD_POS_W-1:0] cmd_pos = '0;
	logic                          reversing = 1'b0;
	logic signed [FIELD_POS_W-1:0] spool_a = '0;
	logic signed [FIELD_POS_W-1:0] spool_b = FIELD_POS_W'(MAX_TRAVEL_RST);
	logic signed [FIELD_POS_W-1:0] grow_a = '0;
	logic signed [FIELD_POS_W-1:0] grow_b = '0;
	logic                          got_a = 1'b0;
	logic                          got_b = 1'b0;
	logic                          err_return = 1'b0;
	logic                          cal_current = 1'b0;

	traverse_winder_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic signed [FIELD_POS_W-1:0] win_lo();
		logic signed [FIELD_POS_W-1:0] s, e;
		s = spool_a - grow_a;
		e = spool_b + grow_b;
		return (s <= e) ? s : e;
	endfunction

	function automatic logic signed [FIELD_POS_W-1:0] win_hi();
		logic signed [FIELD_POS_W-1:0] s, e;
		s = spool_a - grow_a;
		e = spool_b + grow_b;
		return (e >= s) ? e : s;
	endfunction

	function automatic longint fit(input longint v);
		longint lo, hi;
		lo = win_lo();
		hi = win_hi();
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v;
	endfunction

	task automatic start_homing(input logic keep, inout result_t r);
		err_return = keep;
		if (!keep) begin
			got_a = 1'b0;
			got_b = 1'b0;
			spool_a = '0;
			spool_b = FIELD_POS_W'(cfg_travel);
			grow_a = '0;
			grow_b = '0;
		end
		r.zero_pos = 1'b1;
		cmd_pos = FIELD_POS_W'(cfg_travel);
		r.wr_target = 1'b1;
		r.stall_stop = SS_ENABLE;
		wmode = CODE_HOMING;
	endtask

	task automatic advance_traverse(input command_t w);
		result_t r;
		longint two_max, mag, nxt, lo, hi, d;
		r.wr_target = 1'b0;
		r.zero_pos = 1'b0;
		r.stall_stop = SS_KEEP;
		r.reinit = 1'b0;
		two_max = longint'(cfg_travel) * 2;
		case (w.cmd) inside
			CMD_TICK: begin
				if (wmode == CODE_HOMING) begin
					if (w.stalled) begin
						r.stall_stop = SS_DISABLE;
						r.zero_pos = 1'b1;
						cmd_pos = '0;
						tick_count = '0;
						back_mode = CODE_TO_HOME;
						wmode = CODE_WAIT;
					end else begin
						cmd_pos = FIELD_POS_W'(two_max);
						r.wr_target = 1'b1;
					end
				end else if (wmode == CODE_TO_HOME) begin
					cmd_pos = FIELD_POS_W'(-longint'(cfg_travel));
					r.wr_target = 1'b1;
					if (w.reached) begin
						r.zero_pos = 1'b1;
						if (!err_return) begin
							cmd_pos = FIELD_POS_W'(cfg_travel >> 1);
							wmode = CODE_IDLE;
						end else begin
							cmd_pos = win_lo();
							wmode = CODE_AUTO;
						end
					end
				end else if (wmode == CODE_CALIB) begin
					if (w.stalled) begin
						r.stall_stop = SS_DISABLE;
						if (!got_a) begin
							spool_a = w.actual;
							got_a = 1'b1;
							cmd_pos = FIELD_POS_W'(two_max);
							r.wr_target = 1'b1;
							r.stall_stop = SS_ENABLE;
						end else if (!got_b) begin
							spool_b = w.actual;
							got_b = 1'b1;
							cal_current = 1'b0;
							cmd_pos = spool_a;
							r.wr_target = 1'b1;
						end
					end else if (got_a && got_b && w.reached) begin
						wmode = CODE_AUTO;
					end
				end else if (wmode == CODE_WAIT) begin
					if (tick_count < 7'd127) tick_count++;
					if (tick_count >= DEF_HOME_WAIT_TICKS) wmode = back_mode;
				end
				if (!w.drv_en) begin
					r.reinit = 1'b1;
					start_homing(1'b1, r);
				end
			end
			CMD_REV: begin
				if (wmode == CODE_AUTO) begin
					mag = (longint'(cfg_step) * 27 + 10) / 20;
					nxt = longint'(cmd_pos) + (reversing ? -mag : mag);
					lo = win_lo();
					hi = win_hi();
					if (nxt >= hi) begin
						reversing = 1'b1;
						nxt = hi;
					end else if (nxt <= lo) begin
						reversing = 1'b0;
						nxt = lo;
					end
					cmd_pos = FIELD_POS_W'(fit(nxt));
					r.wr_target = 1'b1;
				end
			end
			CMD_LEFT: begin
				cmd_pos = FIELD_POS_W'(fit(longint'(cmd_pos) - longint'(cfg_step)));
				r.wr_target = 1'b1;
			end
			CMD_RIGHT: begin
				cmd_pos = FIELD_POS_W'(fit(longint'(cmd_pos) + longint'(cfg_step)));
				r.wr_target = 1'b1;
			end
			CMD_REHOME: begin
				start_homing(w.aft_err, r);
			end
			CMD_CALIBRATE: begin
				cal_current = 1'b1;
				r.stall_stop = SS_ENABLE;
				cmd_pos = FIELD_POS_W'(-two_max);
				r.wr_target = 1'b1;
				wmode = CODE_CALIB;
			end
			CMD_START_INC, CMD_START_DEC, CMD_END_INC, CMD_END_DEC: begin
				if (got_a && got_b) begin
					d = (w.cmd == CMD_START_INC || w.cmd == CMD_END_INC) ?
						longint'(cfg_step) : -longint'(cfg_step);
					if (w.cmd == CMD_START_INC || w.cmd == CMD_START_DEC)
						grow_a = FIELD_POS_W'(grow_a + d);
					else grow_b = FIELD_POS_W'(grow_b + d);
				end
			end
			default: begin
			end
		endcase
		r.target = cmd_pos;
		r.cal_mode = cal_current;
		r.code = wmode;
		r.calibrated = got_a && got_b;
		r.lim_lo = win_lo();
		r.lim_hi = win_hi();
		due_results.push_back(r);
	endtask

	function automatic int pick_pause();
		int r;
		if ($urandom_range(0, 63) == 0) quiet = !quiet;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic match_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		result_t e;
		if (due_results.size() == 0) begin
			$display("%0t: result word with nothing expected, actual %h", $time, m_axis_tdata);
			errors++;
		end else begin
			e = due_results.pop_front();
			checked++;
			match_field("target_write", e.wr_target, m_axis_tdata[O_WR]);
			match_field("target_position", e.target, $signed(m_axis_tdata[O_TARGET +: 32]));
			match_field("zero_positions", e.zero_pos, m_axis_tdata[O_ZERO]);
			match_field("stall_stop", e.stall_stop, m_axis_tdata[O_SS +: 2]);
			match_field("calibration_mode", e.cal_mode, m_axis_tdata[O_CMODE]);
			match_field("driver_reinit", e.reinit, m_axis_tdata[O_REINIT]);
			match_field("state_code", e.code, m_axis_tdata[O_CODE +: 3]);
			match_field("calibrated", e.calibrated, m_axis_tdata[O_CAL]);
			match_field("limit_start", e.lim_lo, $signed(m_axis_tdata[O_LO +: 32]));
			match_field("limit_end", e.lim_hi, $signed(m_axis_tdata[O_HI +: 32]));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) advance_traverse(cur_cmd);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_pause > 0) begin
					send_pause--;
					s_axis_tvalid <= 1'b0;
				end else if (queued_commands.size() != 0) begin
					cur_cmd = queued_commands.pop_front();
					s_axis_tuser <= cur_cmd.cmd;
					s_axis_tdata <= {4'b0000, cur_cmd.aft_err, cur_cmd.drv_en, cur_cmd.actual,
						cur_cmd.reached, cur_cmd.stalled};
					s_axis_tvalid <= 1'b1;
					send_pause = pick_pause();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) check_result();
			if (recv_pause > 0) begin
				recv_pause--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_pause = pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_SIZE: cfg_step = cfg_data[STEP_W-1:0];
				REG_MAX_TRAVEL: cfg_travel = cfg_data[TRAVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	function automatic command_t word(input logic [CMD_W-1:0] c, input logic st, input logic rc,
		input logic signed [FIELD_POS_W-1:0] act, input logic de, input logic ae);
		command_t w;
		w.cmd = c;
		w.stalled = st;
		w.reached = rc;
		w.actual = act;
		w.drv_en = de;
		w.aft_err = ae;
		return w;
	endfunction

	function automatic command_t mk(input logic [CMD_W-1:0] c);
		return word(c, coin(), coin(), $urandom, $urandom_range(0, 199) != 0, coin());
	endfunction

	function automatic logic signed [FIELD_POS_W-1:0] spot();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom;
		if (r == 1) return 32'sh7fff0000 + int'($urandom_range(0, 65535));
		if (r == 2) return -32'sh7fff0000 - int'($urandom_range(0, 65535));
		return int'($urandom_range(0, 40000)) - 20000;
	endfunction

	task automatic put(input command_t w);
		queued_commands.push_back(w);
		queued++;
	endtask

	task automatic put_tick(input logic st, input logic rc, input logic signed [31:0] act);
		command_t w;
		w = mk(CMD_TICK);
		w.stalled = st;
		w.reached = rc;
		w.actual = act;
		put(w);
	endtask

	task automatic add_traffic();
		int r;
		command_t w;
		repeat ($urandom_range(5, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 55) put(mk(CMD_REV));
			else if (r < 63) put(mk(CMD_LEFT));
			else if (r < 71) put(mk(CMD_RIGHT));
			else if (r < 85) put(mk(CMD_W'($urandom_range(CMD_START_INC, CMD_END_DEC))));
			else if (r < 93) put_tick(coin(), coin(), $urandom);
			else begin
				w = mk(CMD_W'($urandom_range(CMD_TICK, CMD_UNUSED_HI)));
				w.drv_en = coin();
				put(w);
			end
		end
	endtask

	task automatic add_homing();
		command_t w;
		if ($urandom_range(0, 1)) begin
			put(mk(CMD_REHOME));
		end else begin
			w = mk(CMD_TICK);
			w.drv_en = 1'b0;
			put(w);
		end
		repeat ($urandom_range(0, 4)) put_tick(1'b0, coin(), $urandom);
		put_tick(1'b1, coin(), $urandom);
		repeat (DEF_HOME_WAIT_TICKS) put_tick(coin(), coin(), $urandom);
		repeat ($urandom_range(0, 3)) put_tick(coin(), 1'b0, $urandom);
		put_tick(coin(), 1'b1, $urandom);
		add_traffic();
	endtask

	task automatic add_calibration();
		logic signed [FIELD_POS_W-1:0] a, b;
		put(mk(CMD_CALIBRATE));
		repeat ($urandom_range(0, 3)) put_tick(1'b0, coin(), $urandom);
		a = spot();
		put_tick(1'b1, coin(), a);
		repeat ($urandom_range(0, 3)) put_tick(1'b0, 1'b0, $urandom);
		if ($urandom_range(0, 9) < 7) b = a + int'($urandom_range(0, 40000)) - 10000;
		else b = spot();
		put_tick(1'b1, coin(), b);
		repeat ($urandom_range(0, 2)) put_tick(1'b0, 1'b0, $urandom);
		put_tick(1'b0, 1'b1, $urandom);
		add_traffic();
	endtask

	task automatic fill_random(input int n);
		int stop, pick;
		stop = queued + n;
		add_homing();
		while (queued < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) add_calibration();
			else if (pick < 45) add_homing();
			else add_traffic();
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (checked < queued || queued_commands.size() != 0 || s_axis_tvalid ||
			due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		put(word(CMD_UNUSED_HI, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b1));
		put(word(CMD_LEFT, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_RIGHT, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_REV, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_START_INC, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0));
		put(word(CMD_TICK, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b1, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b0, 1'b1, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_REHOME, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_CALIBRATE, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b1, 1'b0, -32'sd5000, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b0, 1'b1, 32'sd123, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b1, 1'b0, 32'sd7000, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b1, 1'b0, 32'sd9000, 1'b1, 1'b0));
		put(word(CMD_TICK, 1'b0, 1'b1, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_START_INC, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_START_DEC, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_END_INC, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_END_INC, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_REV, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_REV, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		put(word(CMD_UNUSED_LO, 1'b0, 1'b0, 32'sh80000000, 1'b0, 1'b0));
		put(word(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 1'b1, 1'b0,
			32'sh7fffffff, 1'b1, 1'b1));
		put(word(CMD_END_DEC, 1'b0, 1'b0, 32'sd0, 1'b1, 1'b0));
		fill_random(210);
		drain();

		write_reg(REG_STEP_SIZE, CFG_DATA_W'(1));
		write_reg(REG_MAX_TRAVEL, CFG_DATA_W'(1));
		fill_random(220);
		drain();

		write_reg(REG_STEP_SIZE, CFG_DATA_W'(20'hFFFFF));
		write_reg(REG_MAX_TRAVEL, CFG_DATA_W'(29'h1FFFFFFF));
		fill_random(220);
		drain();

		write_reg(REG_STEP_SIZE, CFG_DATA_W'($urandom_range(2, 5000)));
		write_reg(REG_MAX_TRAVEL, CFG_DATA_W'($urandom_range(1000, 2000000)));
		fill_random(220);
		drain();

		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/twc_pkg.sv
sv/traverse_winder_controller.sv
test/tb_traverse_winder_controller.sv
